// ===== rtl/imd_pkg.sv =====
// Package for the integer matrix determinant core: types and constants.
package imd_pkg;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_INIT,
      ST_READ,
      ST_MUL,
      ST_ACC,
      ST_STORE,
      ST_OUT
   } state_type;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned ORDER_W = 4;

endpackage

// ===== rtl/integer_matrix_determinant_core.sv =====
// Top level: determinant of an integer matrix by subset minor expansion.
//
//   channel | direction | ports                          | handshake
//   req     | in        | req_element                    | req_valid / req_ready
//   rsp     | out       | rsp_det_value                  | rsp_valid / rsp_ready
//   csr     | in        | csr_matrix_order               | csr_write_enable
//
// The last element starts a sequencer over all non-empty column subsets. Each term
// passes the read, multiply and accumulate states through one shared 32x32 multiplier,
// each absent column only the read state, and each subset a store state for its minor.
// Reset is synchronous and clears the control state only.
// A result waiting in rsp holds back the next result; loading of the next matrix goes on.
module integer_matrix_determinant_core
   import imd_pkg::*;
#(
   parameter int unsigned MAX_ORDER = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [WORD_W-1:0]  req_element,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [WORD_W-1:0]  rsp_det_value,
   input  logic                      csr_write_enable,
   input  logic [ORDER_W-1:0]        csr_matrix_order
);

   localparam int unsigned DEPTH   = MAX_ORDER * MAX_ORDER;
   localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
   localparam int unsigned SUBS    = 1 << MAX_ORDER;
   localparam int unsigned MASK_W  = MAX_ORDER + 1;
   localparam int unsigned COL_W   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int unsigned CIDX_W  = $clog2(MAX_ORDER + 1);
   localparam int unsigned SIDX_W  = MAX_ORDER;

   // Matrix store and minor store
   logic [WORD_W-1:0] mat_mem [DEPTH];
   logic [WORD_W-1:0] min_mem [SUBS];

   state_type state_ff, state_in;
   logic [ORDER_W-1:0] order_ff, order_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic [CIDX_W-1:0]  col_ff, col_in;
   logic               neg_ff, neg_in;
   logic [WORD_W-1:0]  acc_ff, acc_in;
   logic [WORD_W-1:0]  mat_rd_ff, min_rd_ff, prod_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_data_ff;

   // Effective order, saturated to 1..MAX_ORDER
   logic [CIDX_W-1:0] n_eff;
   always_comb begin
      if (order_ff == '0) begin
         n_eff = CIDX_W'(1);
      end else if (32'(order_ff) > MAX_ORDER) begin
         n_eff = CIDX_W'(MAX_ORDER);
      end else begin
         n_eff = CIDX_W'(order_ff);
      end
   end

   logic [CNT_W-1:0]  total;
   logic [MASK_W-1:0] full_mask;
   logic [CIDX_W-1:0] pop;
   logic [CIDX_W-1:0] row_r;
   logic [ADDR_W-1:0] mat_addr;
   logic [SIDX_W-1:0] sub_addr;
   logic              col_in_mask;
   logic              last_col;
   logic              load_fire;

   assign total     = CNT_W'(n_eff) * CNT_W'(n_eff);
   assign full_mask = (MASK_W'(1) << n_eff) - MASK_W'(1);
   assign load_fire = req_valid && req_ready;

   always_comb begin
      pop = '0;
      for (int i = 0; i < MAX_ORDER; i++) begin
         pop = pop + CIDX_W'(mask_ff[i]);
      end
   end

   assign row_r       = n_eff - pop;
   assign mat_addr    = ADDR_W'(row_r) * ADDR_W'(n_eff) + ADDR_W'(col_ff);
   assign col_in_mask = mask_ff[col_ff[COL_W-1:0]] && (col_ff < n_eff);
   assign sub_addr    = SIDX_W'(mask_ff & ~(MASK_W'(1) << col_ff));
   assign last_col    = (col_ff == n_eff - CIDX_W'(1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (load_fire && (count_ff + CNT_W'(1) >= total)) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT:  state_in = ST_READ;
         ST_READ: begin
            if (col_in_mask) begin
               state_in = ST_MUL;
            end else if (last_col) begin
               state_in = ST_STORE;
            end
         end
         ST_MUL:   state_in = ST_ACC;
         ST_ACC:   state_in = last_col ? ST_STORE : ST_READ;
         ST_STORE: state_in = (mask_ff == full_mask) ? ST_OUT : ST_READ;
         ST_OUT:   state_in = (rsp_valid_ff) ? ST_OUT : ST_LOAD;
         default:  state_in = ST_LOAD;
      endcase
   end

   // Datapath controls
   always_comb begin
      order_in     = order_ff;
      count_in     = count_ff;
      mask_in      = mask_ff;
      col_in       = col_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_LOAD: begin
            if (load_fire) begin
               count_in = (count_ff + CNT_W'(1) >= total) ? '0 : count_ff + CNT_W'(1);
            end
         end
         ST_INIT: begin
            mask_in = MASK_W'(1);
            col_in  = '0;
            neg_in  = 1'b0;
            acc_in  = '0;
         end
         ST_READ: begin
            if (!col_in_mask && !last_col) begin
               col_in = col_ff + CIDX_W'(1);
            end
         end
         ST_ACC: begin
            acc_in = neg_ff ? acc_ff - prod_ff : acc_ff + prod_ff;
            neg_in = !neg_ff;
            if (!last_col) begin
               col_in = col_ff + CIDX_W'(1);
            end
         end
         ST_STORE: begin
            mask_in = mask_ff + MASK_W'(1);
            col_in  = '0;
            neg_in  = 1'b0;
            acc_in  = '0;
         end
         ST_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
      if (csr_write_enable) begin
         order_in = csr_matrix_order;
         count_in = '0;
      end
   end

   assign req_ready     = (state_ff == ST_LOAD);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_det_value = signed'(rsp_data_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         order_ff     <= ORDER_W'(1);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         order_ff     <= order_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sequencer working registers
   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      col_ff  <= col_in;
      neg_ff  <= neg_in;
      acc_ff  <= acc_in;
   end

   // Matrix store: write on load, read the term element
   always_ff @(posedge clock) begin
      if (load_fire) begin
         mat_mem[ADDR_W'(count_ff)] <= req_element;
      end
      mat_rd_ff <= mat_mem[mat_addr];
   end

   // Minor store: write finished minors, read the minor of the remaining subset
   always_ff @(posedge clock) begin
      if (state_ff == ST_STORE) begin
         min_mem[SIDX_W'(mask_ff)] <= acc_ff;
      end
      min_rd_ff <= min_mem[sub_addr];
   end

   // Shared multiplier; empty minor counts as one
   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_ff <= (mask_ff == (MASK_W'(1) << col_ff)) ?
                    mat_rd_ff : WORD_W'(mat_rd_ff * min_rd_ff);
      end
   end

   // Result word
   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && !rsp_valid_ff) begin
         rsp_data_ff <= min_mem[SIDX_W'(full_mask)];
      end
   end

endmodule
